// ===== rtl/ig_pkg.sv =====
package ig_pkg;

    localparam int unsigned DIV_STAGES = 64;
    localparam int unsigned GAMMA_W = 18;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd109227;
    localparam logic [18:0] ONE_Q16 = 19'd65536;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic [63:0] KIN_CLAMP = 64'd8589934592;
    localparam logic [63:0] POS_LIMIT = 64'd2147483647;
    localparam logic [63:0] NEG_LIMIT = 64'd2147483648;

    localparam int unsigned LANE_KIN = 3;

    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] dq;
    } ig_lane_t;

    typedef struct packed {
        ig_lane_t [3:0]     lane;
        logic [30:0]        dens;
        logic [2:0]         neg;
        logic signed [31:0] etot;
        logic               bad;
    } ig_div_t;

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -36'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic over36(input logic signed [35:0] v);
        return (v > 36'sd2147483647) || (v < -36'sd2147483648);
    endfunction

endpackage

// ===== rtl/ig_cell_if.sv =====
interface ig_cell_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] total_energy;

    modport source (output valid, output density, output momentum_x, output momentum_y,
                    output momentum_z, output total_energy, input ready);
    modport sink (input valid, input density, input momentum_x, input momentum_y,
                  input momentum_z, input total_energy, output ready);
endinterface

// ===== rtl/ig_prim_if.sv =====
interface ig_prim_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pressure;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic signed [31:0] internal_energy;
    logic [1:0]         status;

    modport source (output valid, output pressure, output velocity_x, output velocity_y,
                    output velocity_z, output internal_energy, output status, input ready);
    modport sink (input valid, input pressure, input velocity_x, input velocity_y,
                  input velocity_z, input internal_energy, input status, output ready);
endinterface

// ===== rtl/ig_cfg.sv =====
module ig_cfg
    import ig_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [GAMMA_W-1:0] gamma
);
    logic [GAMMA_W-1:0] gamma_reg;
    logic [GAMMA_W-1:0] gamma_next;

    assign pready = 1'b1;
    assign gamma  = gamma_reg;

    always_comb
    begin
        gamma_next = gamma_reg;
        if (psel && penable && pwrite && !paddr[2])
        begin
            gamma_next = pwdata[GAMMA_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (!paddr[2])
        begin
            prdata = {{(32-GAMMA_W){1'b0}}, gamma_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
        end
        else
        begin
            gamma_reg <= gamma_next;
        end
    end
endmodule

// ===== rtl/ig_pre.sv =====
module ig_pre
    import ig_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ig_cell_if.sink  cons,
    output logic     out_valid,
    input  logic     out_ready,
    output ig_div_t  out_data
);
    logic               a_valid_reg;
    logic [63:0]        a_sq_reg [3];
    logic [31:0]        a_mag_reg [3];
    logic [2:0]         a_neg_reg;
    logic [30:0]        a_dens_reg;
    logic               a_bad_reg;
    logic signed [31:0] a_etot_reg;
    logic               b_valid_reg;
    ig_div_t            b_data_reg;
    ig_div_t            b_data_next;
    logic               a_ready;
    logic               b_ready;
    logic signed [31:0] mom [3];
    logic [31:0]        mag [3];

    assign b_ready    = !b_valid_reg || out_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign cons.ready = a_ready;
    assign out_valid  = b_valid_reg;
    assign out_data   = b_data_reg;

    assign mom[0] = cons.momentum_x;
    assign mom[1] = cons.momentum_y;
    assign mom[2] = cons.momentum_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mom[i][31] ? (~mom[i] + 32'd1) : mom[i];
        end
    end

    always_comb
    begin
        b_data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            b_data_next.lane[i].dq = {16'd0, a_mag_reg[i], 16'd0};
        end
        b_data_next.lane[LANE_KIN].dq = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
        b_data_next.dens = a_dens_reg;
        b_data_next.neg  = a_neg_reg;
        b_data_next.etot = a_etot_reg;
        b_data_next.bad  = a_bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= cons.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cons.valid && a_ready)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_sq_reg[i]  <= mag[i] * mag[i];
                a_mag_reg[i] <= mag[i];
                a_neg_reg[i] <= mom[i][31];
            end
            a_dens_reg <= cons.density[30:0];
            a_bad_reg  <= cons.density[31] || (cons.density == 32'sd0);
            a_etot_reg <= cons.total_energy;
        end
        if (a_valid_reg && b_ready)
        begin
            b_data_reg <= b_data_next;
        end
    end
endmodule

// ===== rtl/ig_div_stage.sv =====
module ig_div_stage
    import ig_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  ig_div_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output ig_div_t out_data
);
    logic    valid_reg;
    ig_div_t data_reg;
    ig_div_t data_next;
    logic [32:0] dvs [4];
    logic [32:0] sh [4];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < 4; i++)
        begin
            dvs[i] = (i == LANE_KIN) ? {1'b0, in_data.dens, 1'b0} : {2'b00, in_data.dens};
            sh[i]  = {in_data.lane[i].rem, in_data.lane[i].dq[63]};
            if (sh[i] >= dvs[i])
            begin
                data_next.lane[i].rem = 32'(sh[i] - dvs[i]);
                data_next.lane[i].dq  = {in_data.lane[i].dq[62:0], 1'b1};
            end
            else
            begin
                data_next.lane[i].rem = sh[i][31:0];
                data_next.lane[i].dq  = {in_data.lane[i].dq[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end
endmodule

// ===== rtl/ig_post.sv =====
module ig_post
    import ig_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ig_div_t            in_data,
    input  logic [GAMMA_W-1:0] gamma,
    ig_prim_if.source          prim
);
    logic               c_valid_reg;
    logic signed [31:0] c_vel_reg [3];
    logic signed [31:0] c_eint_reg;
    logic               c_sat_reg;
    logic               c_bad_reg;
    logic               d_valid_reg;
    logic signed [50:0] d_prod_reg;
    logic signed [31:0] d_vel_reg [3];
    logic signed [31:0] d_eint_reg;
    logic               d_sat_reg;
    logic               d_bad_reg;
    logic               e_valid_reg;
    logic signed [31:0] e_press_reg;
    logic signed [31:0] e_vel_reg [3];
    logic signed [31:0] e_eint_reg;
    logic [1:0]         e_status_reg;
    logic               c_ready;
    logic               d_ready;
    logic               e_ready;
    logic signed [31:0] vel [3];
    logic [2:0]         vel_sat;
    logic [33:0]        kin;
    logic signed [35:0] ediff;
    logic signed [18:0] gm1;
    logic signed [35:0] pshift;
    logic               press_sat;

    assign e_ready  = !e_valid_reg || prim.ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vel_sat[i] = 1'b0;
            vel[i]     = 32'(-in_data.lane[i].dq);
            if (in_data.neg[i])
            begin
                if (in_data.lane[i].dq > NEG_LIMIT)
                begin
                    vel[i]     = 32'sh80000000;
                    vel_sat[i] = 1'b1;
                end
            end
            else if (in_data.lane[i].dq > POS_LIMIT)
            begin
                vel[i]     = 32'sh7fffffff;
                vel_sat[i] = 1'b1;
            end
            else
            begin
                vel[i] = in_data.lane[i].dq[31:0];
            end
        end
        kin = (in_data.lane[LANE_KIN].dq > KIN_CLAMP) ? KIN_CLAMP[33:0]
                                                      : in_data.lane[LANE_KIN].dq[33:0];
        ediff = {{4{in_data.etot[31]}}, in_data.etot} - {2'b00, kin};
    end

    assign gm1       = $signed({1'b0, gamma} - ONE_Q16);
    assign pshift    = {d_prod_reg[50], d_prod_reg[50:16]};
    assign press_sat = over36(pshift);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= in_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && c_ready)
        begin
            c_vel_reg  <= vel;
            c_eint_reg <= sat36(ediff);
            c_sat_reg  <= (|vel_sat) || over36(ediff);
            c_bad_reg  <= in_data.bad;
        end
        if (c_valid_reg && d_ready)
        begin
            d_prod_reg <= $signed({{19{c_eint_reg[31]}}, c_eint_reg})
                        * $signed({{32{gm1[18]}}, gm1});
            d_vel_reg  <= c_vel_reg;
            d_eint_reg <= c_eint_reg;
            d_sat_reg  <= c_sat_reg;
            d_bad_reg  <= c_bad_reg;
        end
        if (d_valid_reg && e_ready)
        begin
            if (d_bad_reg)
            begin
                e_press_reg  <= '0;
                e_vel_reg    <= '{default: '0};
                e_eint_reg   <= '0;
                e_status_reg <= ST_BAD;
            end
            else
            begin
                e_press_reg  <= sat36(pshift);
                e_vel_reg    <= d_vel_reg;
                e_eint_reg   <= d_eint_reg;
                e_status_reg <= (d_sat_reg || press_sat) ? ST_SAT : ST_OK;
            end
        end
    end

    assign prim.valid           = e_valid_reg;
    assign prim.pressure        = e_press_reg;
    assign prim.velocity_x      = e_vel_reg[0];
    assign prim.velocity_y      = e_vel_reg[1];
    assign prim.velocity_z      = e_vel_reg[2];
    assign prim.internal_energy = e_eint_reg;
    assign prim.status          = e_status_reg;
endmodule

// ===== rtl/ideal_gas_cons_to_prim.sv =====
// Structure: 2 entry stages, 64 restoring divider stages (one quotient bit per stage) and 3
// finishing stages. Throughput: one cell per cycle unless prim.ready stalls the output;
// every stage is a skid-free register that fills bubbles.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and sets gamma to 5/3.
module ideal_gas_cons_to_prim
    import ig_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ig_cell_if.sink     cons,
    ig_prim_if.source   prim
);
    logic [GAMMA_W-1:0] gamma;
    logic               stg_valid [DIV_STAGES+1];
    logic               stg_ready [DIV_STAGES+1];
    ig_div_t            stg_data [DIV_STAGES+1];

    ig_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gamma   (gamma)
    );

    ig_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .cons      (cons),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        ig_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    ig_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[DIV_STAGES]),
        .in_ready (stg_ready[DIV_STAGES]),
        .in_data  (stg_data[DIV_STAGES]),
        .gamma    (gamma),
        .prim     (prim)
    );

`ifndef SYNTHESIS
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !cons.ready |-> (prim.valid && !prim.ready))
        else $error("Input stalled while the output is free.");

    a_bad_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (prim.valid && prim.status == ST_BAD) |-> (prim.pressure == 32'sd0
            && prim.velocity_x == 32'sd0 && prim.velocity_y == 32'sd0
            && prim.velocity_z == 32'sd0 && prim.internal_energy == 32'sd0))
        else $error("Non-positive density result has nonzero fields.");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) |=> (gamma == $past(pwdata[GAMMA_W-1:0])))
        else $error("Gamma register did not take the written value.");
`endif
endmodule
